// File: rtl/ecrc_pkg.sv
package ecrc_pkg;

   // Defaults for the top-level parameters
   localparam int MIN_BODY_BYTES = 60;
   localparam int QUEUE_DEPTH = 2;

   // Fixed frame figures
   localparam int HEADER_BYTES = 14;
   localparam int FCS_BYTES = 4;
   localparam int COUNT_W = 16;
   localparam int PAD_W = 6;   // holds a padding count up to 60 bytes

   localparam logic [31:0] CRC_POLY_REFLECTED = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration register indexes and mode codes
   localparam logic REG_MODE = 1'b0;
   localparam logic MODE_CHECK = 1'b0;
   localparam logic MODE_GENERATE = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] fcs_value;
      logic        fcs_ok;
      logic        length_error;
   } rsp_type;

   // One finished frame handed from the front to the back
   typedef struct packed {
      logic [31:0]      crc;
      logic [31:0]      holdback;
      logic [PAD_W-1:0] pad_count;
      logic             check;
      logic             length_error;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [0:0] {
      BACK_IDLE,
      BACK_PAD
   } back_state_type;

   // Reflected CRC-32 over one byte, one polynomial step per bit
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h000000, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/ecrc_front.sv
module ecrc_front #(
   parameter int MIN_BODY_BYTES = ecrc_pkg::MIN_BODY_BYTES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         mode,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ecrc_pkg::req_type            req_data,
   input  ecrc_pkg::queue_status_type   queue_status,
   output ecrc_pkg::push_type           push
);

   localparam logic [ecrc_pkg::COUNT_W-1:0] MIN_BODY =
      ecrc_pkg::COUNT_W'(MIN_BODY_BYTES);
   localparam logic [ecrc_pkg::COUNT_W-1:0] FCS_LEN =
      ecrc_pkg::COUNT_W'(ecrc_pkg::FCS_BYTES);
   localparam logic [ecrc_pkg::COUNT_W-1:0] MIN_LEN_CHECK =
      ecrc_pkg::COUNT_W'(ecrc_pkg::HEADER_BYTES + ecrc_pkg::FCS_BYTES);
   localparam logic [ecrc_pkg::COUNT_W-1:0] MIN_LEN_GEN =
      ecrc_pkg::COUNT_W'(ecrc_pkg::HEADER_BYTES);

   logic [31:0]                   crc_ff, crc_in;
   logic [31:0]                   hold_ff, hold_in;
   logic [ecrc_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic                          accept;
   logic                          check;
   logic [7:0]                    crc_src;
   logic [31:0]                   crc_upd;
   logic [31:0]                   hold_upd;
   logic [ecrc_pkg::COUNT_W-1:0]  count_upd;
   logic [ecrc_pkg::COUNT_W-1:0]  body;
   logic [ecrc_pkg::COUNT_W-1:0]  pad_full;

   // Hold input while the queue has no room for a finished frame
   assign req_stall = queue_status.full;
   assign accept = req_valid && !req_stall;
   assign check = (mode == ecrc_pkg::MODE_CHECK);

   // Check mode feeds the byte leaving the holdback window, generate mode the new byte
   assign crc_src = check ? hold_ff[31:24] : req_data.data_byte;

   always_comb begin
      crc_upd = crc_ff;
      if (!check || (count_ff >= FCS_LEN)) begin
         crc_upd = ecrc_pkg::crc_byte(crc_ff, crc_src);
      end
      hold_upd = check ? {hold_ff[23:0], req_data.data_byte} : hold_ff;
      count_upd = (count_ff == ecrc_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
   end

   // Classify the frame on its last byte
   always_comb begin
      if (check) begin
         body = (count_upd >= FCS_LEN) ? count_upd - FCS_LEN : '0;
      end else begin
         body = count_upd;
      end
      pad_full = (body < MIN_BODY) ? MIN_BODY - body : '0;

      push.valid = accept && req_data.last;
      push.job.crc = crc_upd;
      push.job.holdback = hold_upd;
      push.job.pad_count = pad_full[ecrc_pkg::PAD_W-1:0];
      push.job.check = check;
      push.job.length_error = count_upd < (check ? MIN_LEN_CHECK : MIN_LEN_GEN);
   end

   // Advance the running state, clear it at frame end
   always_comb begin
      crc_in = crc_ff;
      hold_in = hold_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_data.last) begin
            crc_in = ecrc_pkg::CRC_INIT;
            hold_in = '0;
            count_in = '0;
         end else begin
            crc_in = crc_upd;
            hold_in = hold_upd;
            count_in = count_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= ecrc_pkg::CRC_INIT;
         hold_ff <= '0;
         count_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         hold_ff <= hold_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/ecrc_queue.sv
module ecrc_queue #(
   parameter int DEPTH = ecrc_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ecrc_pkg::push_type          push,
   input  logic                        pop,
   output ecrc_pkg::job_type           head,
   output ecrc_pkg::queue_status_type  status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ecrc_pkg::job_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   assign status.full = (cnt_ff == FULL_CNT);
   assign status.empty = (cnt_ff == '0);
   assign head = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap, track the fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push.valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// File: rtl/ecrc_back.sv
module ecrc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ecrc_pkg::job_type           head,
   input  ecrc_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ecrc_pkg::rsp_type           rsp_data
);

   ecrc_pkg::back_state_type     state_ff, state_in;
   logic [31:0]                  crc_ff, crc_in;
   logic [ecrc_pkg::PAD_W-1:0]   pad_ff, pad_in;
   logic [31:0]                  hold_ff, hold_in;
   logic                         check_ff, check_in;
   logic                         lerr_ff, lerr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ecrc_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                         out_free;
   logic                         load;
   logic                         step;
   logic                         emit;
   logic [31:0]                  crc_inv;
   logic [31:0]                  fcs;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ecrc_pkg::BACK_IDLE: begin
            if (!queue_status.empty) begin
               state_in = ecrc_pkg::BACK_PAD;
            end
         end
         ecrc_pkg::BACK_PAD: begin
            if ((pad_ff == '0) && out_free) begin
               state_in = ecrc_pkg::BACK_IDLE;
            end
         end
         default: state_in = ecrc_pkg::BACK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      load = 1'b0;
      step = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         ecrc_pkg::BACK_IDLE: load = !queue_status.empty;
         ecrc_pkg::BACK_PAD: begin
            step = (pad_ff != '0);
            emit = (pad_ff == '0) && out_free;
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign pop = load;

   // Finish the CRC: invert and lay out the first wire byte on top
   assign crc_inv = ~crc_ff;
   assign fcs = {crc_inv[7:0], crc_inv[15:8], crc_inv[23:16], crc_inv[31:24]};

   // Load a job, then shift in one zero pad byte per cycle
   always_comb begin
      crc_in = crc_ff;
      pad_in = pad_ff;
      hold_in = hold_ff;
      check_in = check_ff;
      lerr_in = lerr_ff;
      if (load) begin
         crc_in = head.crc;
         pad_in = head.pad_count;
         hold_in = head.holdback;
         check_in = head.check;
         lerr_in = head.length_error;
      end else if (step) begin
         crc_in = ecrc_pkg::crc_byte(crc_ff, 8'h00);
         pad_in = pad_ff - 1'b1;
      end
   end

   // Output register: drop on transfer, fill on emit
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.fcs_value = fcs;
         rsp_data_in.length_error = lerr_ff;
         rsp_data_in.fcs_ok = check_ff && !lerr_ff && (hold_ff == fcs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecrc_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      pad_ff <= pad_in;
      hold_ff <= hold_in;
      check_ff <= check_in;
      lerr_ff <= lerr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/ethernet_fcs_crc32_unit.sv
// Ethernet FCS unit: takes a frame one byte per transfer (last marks the end) and
// returns one result per frame holding the CRC-32 FCS, a check flag and a
// length flag. mode 0 treats the final four bytes as the received FCS and
// compares; mode 1 produces the FCS to append. Bytes are taken at one per clock,
// unless the input stalls, by the front end, which keeps the running CRC. At the
// last byte the frame is queued for the back end, which loads the frame, then
// shifts in zero pad bytes one by one (MIN_BODY_BYTES minus the body length,
// none for bodies of MIN_BODY_BYTES or more), then places the result in the
// output register once that register is free. The queue holds QUEUE_DEPTH
// finished frames, and the input stalls on any byte while the queue is full:
// when a run of short frames outpaces the padding loop, or when the result
// side holds results back. Register 0 (mode) lies at byte address 0 and
// should be written only while the unit is idle.
module ethernet_fcs_crc32_unit #(
   parameter int MIN_BODY_BYTES = ecrc_pkg::MIN_BODY_BYTES,
   parameter int QUEUE_DEPTH = ecrc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  ecrc_pkg::req_type  req_data,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ecrc_pkg::rsp_type  rsp_data,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic                        mode_ff, mode_in;
   logic                        csr_write;
   ecrc_pkg::push_type          push;
   logic                        pop;
   ecrc_pkg::job_type           head;
   ecrc_pkg::queue_status_type  queue_status;

   // Register file: a single mode bit
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && (csr_paddr[2] == ecrc_pkg::REG_MODE)) begin
         mode_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == ecrc_pkg::REG_MODE) begin
         csr_prdata = {31'h0, mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ecrc_pkg::MODE_CHECK;
      end else begin
         mode_ff <= mode_in;
      end
   end

   ecrc_front #(
      .MIN_BODY_BYTES(MIN_BODY_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .mode(mode_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .queue_status(queue_status),
      .push(push)
   );

   ecrc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop(pop),
      .head(head),
      .status(queue_status)
   );

   ecrc_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .queue_status(queue_status),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // A frame is never handed to a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !queue_status.full)
      else $error("frame pushed into full queue");

   // The back end only takes a frame that is there
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("frame popped from empty queue");

   // A frame with a length error never reports a good FCS
   a_ok_excludes_len_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.fcs_ok && rsp_data.length_error))
      else $error("fcs_ok set on a short frame");

endmodule

// File: verif/ethernet_fcs_crc32_unit_test.sv
module ethernet_fcs_crc32_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] FCS_POLY = 32'hEDB8_8320;
   localparam int PAD_TO = 60;
   localparam int HDR_LEN = 14;
   localparam int TRAILER_LEN = 4;
   localparam logic [15:0] LEN_LIMIT = 16'hFFFF;
   localparam int DRAIN_CYCLES = PAD_TO + 8;
   localparam int STALL_LIMIT = 5000;
   localparam logic [2:0] MODE_ADDR = {ecrc_pkg::REG_MODE, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   ecrc_pkg::req_type     req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   ecrc_pkg::rsp_type     rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [2:0]            csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predictor state: mirrors the unit's frame state and mode register
   logic        fcs_mode = ecrc_pkg::MODE_CHECK;
   logic [31:0] crc_run = '1;
   logic [31:0] held_bytes = '0;
   logic [15:0] frame_len = '0;

   ecrc_pkg::rsp_type expected_fcs_q[$];
   logic [7:0]  frame_bytes[$];
   int          send_idle_pct = 31;
   int          recv_idle_pct = 71;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;

   ethernet_fcs_crc32_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Advance the reflected CRC one bit at a time, data bit 0 first
   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ b[k];
         c = {1'b0, c[31:1]} ^ (fb ? FCS_POLY : 32'h0);
      end
      return c;
   endfunction

   // Pad the body with zero bytes, invert and lay the FCS out in wire order
   function automatic logic [31:0] finish_fcs(input logic [31:0] crc, input int body_len);
      logic [31:0] c;
      c = crc;
      for (int n = body_len; n < PAD_TO; n++) begin
         c = crc_step(c, 8'h00);
      end
      c = ~c;
      return {c[7:0], c[15:8], c[23:16], c[31:24]};
   endfunction

   // Work out the result, if any, that one accepted byte causes
   function automatic bit predict_fcs(input ecrc_pkg::req_type item,
                                      output ecrc_pkg::rsp_type res);
      logic in_check;
      int   body;
      int   min_len;
      in_check = (fcs_mode == ecrc_pkg::MODE_CHECK);
      res = '0;
      if (in_check) begin
         if (frame_len >= TRAILER_LEN) begin
            crc_run = crc_step(crc_run, held_bytes[31:24]);
         end
         held_bytes = {held_bytes[23:0], item.data_byte};
      end else begin
         crc_run = crc_step(crc_run, item.data_byte);
      end
      if (frame_len != LEN_LIMIT) begin
         frame_len++;
      end
      if (!item.last) begin
         return 1'b0;
      end
      if (in_check) begin
         body = (frame_len >= TRAILER_LEN) ? int'(frame_len) - TRAILER_LEN : 0;
      end else begin
         body = int'(frame_len);
      end
      res.fcs_value = finish_fcs(crc_run, body);
      min_len = in_check ? HDR_LEN + TRAILER_LEN : HDR_LEN;
      res.length_error = (int'(frame_len) < min_len);
      res.fcs_ok = in_check && !res.length_error && (held_bytes == res.fcs_value);
      crc_run = '1;
      held_bytes = '0;
      frame_len = '0;
      return 1'b1;
   endfunction

   // Build a frame; with add_fcs the last four bytes carry the correct FCS
   function automatic void build_frame(input int len, input bit add_fcs, input bit corrupt,
                                       input int fill_value);
      int          body_len;
      logic [31:0] crc;
      logic [31:0] fcs;
      int          pos;
      body_len = (add_fcs && len >= TRAILER_LEN) ? len - TRAILER_LEN : len;
      frame_bytes.delete();
      crc = '1;
      for (int n = 0; n < body_len; n++) begin
         frame_bytes.insert(frame_bytes.size(),
                            fill_value < 0 ? 8'($urandom) : 8'(fill_value));
         crc = crc_step(crc, frame_bytes[n]);
      end
      if (body_len != len) begin
         fcs = finish_fcs(crc, body_len);
         for (int n = 3; n >= 0; n--) begin
            frame_bytes.insert(frame_bytes.size(), fcs[8*n +: 8]);
         end
      end
      if (corrupt) begin
         pos = $urandom_range(len - 1);
         frame_bytes[pos] = frame_bytes[pos] ^ 8'(1 << $urandom_range(7));
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
   endtask

   // Offer one byte, idling at random first, and hold it until the transfer
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      ecrc_pkg::req_type item;
      ecrc_pkg::rsp_type res;
      item.data_byte = value;
      item.last = is_last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      if (predict_fcs(item, res)) begin
         expected_fcs_q.insert(expected_fcs_q.size(), res);
      end
   endtask

   task automatic send_frame(input bit close);
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i], close && (i == frame_bytes.size() - 1));
      end
   endtask

   // Wait for the unit to go quiet, then write the mode and read it back
   task automatic write_mode(input logic value);
      logic [31:0] readback;
      req_valid <= 1'b0;
      while (expected_fcs_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MODE_ADDR;
      csr_pwdata <= {31'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      fcs_mode = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== {31'b0, value}) begin
         report_mismatch("mode readback", readback, {31'b0, value});
      end
   endtask

   task automatic test_check_mode();
      write_mode(ecrc_pkg::MODE_CHECK);
      // shortest legal frame, then one whose body needs no padding
      build_frame(18, 1, 0, -1); send_frame(1);
      build_frame(64, 1, 0, -1); send_frame(1);
      build_frame(63, 1, 0, -1); send_frame(1);
      build_frame(30, 1, 0, 8'h00); send_frame(1);
      build_frame(30, 1, 0, 8'hFF); send_frame(1);
      // damaged frame and one a byte too short
      build_frame(40, 1, 1, -1); send_frame(1);
      build_frame(17, 1, 0, -1); send_frame(1);
      // frames of up to five bytes, some shorter than the FCS: held bytes shift in from the bottom
      build_frame(1, 0, 0, 8'hAA); send_frame(1);
      build_frame(3, 0, 0, 8'h55); send_frame(1);
      build_frame(4, 0, 0, -1); send_frame(1);
      build_frame(5, 0, 0, 8'hFF); send_frame(1);
   endtask

   task automatic test_generate_mode();
      write_mode(ecrc_pkg::MODE_GENERATE);
      build_frame(1, 0, 0, 8'hFF); send_frame(1);
      build_frame(13, 0, 0, -1); send_frame(1);
      build_frame(14, 0, 0, -1); send_frame(1);
      build_frame(59, 0, 0, -1); send_frame(1);
      build_frame(60, 0, 0, 8'hFF); send_frame(1);
      build_frame(61, 0, 0, 8'h00); send_frame(1);
      build_frame(20, 1, 0, -1); send_frame(1);
   endtask

   // Mode is taken per byte, so switch it part way through a frame
   task automatic test_mode_switch_mid_frame();
      write_mode(ecrc_pkg::MODE_CHECK);
      build_frame(6, 0, 0, -1); send_frame(0);
      write_mode(ecrc_pkg::MODE_GENERATE);
      build_frame(10, 0, 0, -1); send_frame(1);
      build_frame(2, 0, 0, -1); send_frame(0);
      write_mode(ecrc_pkg::MODE_CHECK);
      build_frame(20, 1, 0, -1); send_frame(1);
      build_frame(9, 0, 0, -1); send_frame(0);
      write_mode(ecrc_pkg::MODE_GENERATE);
      build_frame(3, 0, 0, -1); send_frame(0);
      write_mode(ecrc_pkg::MODE_CHECK);
      build_frame(8, 0, 0, -1); send_frame(1);
   endtask

   // Mostly well-formed frames of random length and content, some damaged
   task automatic test_random_frames(input int item_budget);
      int sent;
      int pick;
      int len;
      int quota;
      quota = item_budget / 6;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 71 : 0;
         recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 31 : 0;
         for (int half = 0; half < 2; half++) begin
            write_mode(half == 0 ? ecrc_pkg::MODE_CHECK : ecrc_pkg::MODE_GENERATE);
            sent = 0;
            while (sent < quota) begin
               pick = $urandom_range(99);
               len = (pick < 70) ? $urandom_range(70, 1) :
                     (pick < 90) ? $urandom_range(200, 71) : $urandom_range(300, 201);
               // trim the final frame to what is left of the share
               if (len > quota - sent) begin
                  len = quota - sent;
               end
               pick = $urandom_range(99);
               if (fcs_mode == ecrc_pkg::MODE_CHECK) begin
                  build_frame(len, pick < 85, pick >= 70 && pick < 85, -1);
               end else begin
                  build_frame(len, 0, 0, -1);
               end
               send_frame(1);
               sent += frame_bytes.size();
            end
         end
      end
   endtask

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   // Compare each result transfer with the oldest expectation; watch for a hang
   always @(posedge clock) begin
      ecrc_pkg::rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_fcs_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.fcs_value, '0);
            end else begin
               want = expected_fcs_q.pop_front();
               if (rsp_data.fcs_value !== want.fcs_value) begin
                  report_mismatch("fcs_value", rsp_data.fcs_value, want.fcs_value);
               end
               if (rsp_data.fcs_ok !== want.fcs_ok) begin
                  report_mismatch("fcs_ok", 32'(rsp_data.fcs_ok), 32'(want.fcs_ok));
               end
               if (rsp_data.length_error !== want.length_error) begin
                  report_mismatch("length_error", 32'(rsp_data.length_error),
                                  32'(want.length_error));
               end
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_check_mode();
      test_generate_mode();
      test_mode_switch_mid_frame();
      test_random_frames(486);
      // drain outstanding results, then give stray ones time to show
      req_valid <= 1'b0;
      while (expected_fcs_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/ecrc_pkg.sv
rtl/ecrc_front.sv
rtl/ecrc_queue.sv
rtl/ecrc_back.sv
rtl/ethernet_fcs_crc32_unit.sv
verif/ethernet_fcs_crc32_unit_test.sv
